/* rtl/core/dde_pkg.sv */
// ----------------------------------------------------------------------------
// dde_pkg: shared types, constants and date functions
// Stamp layout, controller commands, calendar tables and day-number arithmetic
// for the date digit editor.
// ----------------------------------------------------------------------------
package dde_pkg;

  // one stamp: digits y y m m d d h h m m, index 0 is the tens of year
  localparam int unsigned NumDigits = 10;
  typedef logic [3:0] digit_t;
  typedef digit_t [NumDigits-1:0] stamp_t;

  // two-digit value 0..99
  typedef logic [6:0] pair_t;
  // day number, 2000-2099 gives well under 2^20
  typedef logic [19:0] day_t;
  typedef logic [11:0] year_t;

  // reset stamp 21/01/01 00:00
  localparam stamp_t ResetStamp = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd1,
                                    4'd0, 4'd1, 4'd0, 4'd1, 4'd2};

  localparam digit_t MaxDigit = 4'd9;
  localparam year_t  BaseYear = 12'd2000;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;   // capture the item
    logic edit;      // apply, check and commit the digit
    logic day_cur;   // day number of the current stamp
    logic day_tgt;   // day number of the target stamp
    logic result;    // form the difference and strobe the result
  } dde_cmd_t;

  // character position to digit slot
  typedef struct packed {
    logic       is_digit;
    logic [3:0] slot;
  } dde_slot_t;

  function automatic dde_slot_t slot_of_pos(input logic [3:0] pos);
    dde_slot_t s;
    s.is_digit = 1'b1;
    case (pos)
      4'd0:  s.slot = 4'd0;
      4'd1:  s.slot = 4'd1;
      4'd3:  s.slot = 4'd2;
      4'd4:  s.slot = 4'd3;
      4'd6:  s.slot = 4'd4;
      4'd7:  s.slot = 4'd5;
      4'd9:  s.slot = 4'd6;
      4'd10: s.slot = 4'd7;
      4'd12: s.slot = 4'd8;
      4'd13: s.slot = 4'd9;
      default: begin
        s.is_digit = 1'b0;
        s.slot     = 4'd0;
      end
    endcase
    return s;
  endfunction

  // tens and units to a value
  function automatic pair_t pair_value(input digit_t tens, input digit_t units);
    return pair_t'({3'd0, tens} * 7'd10) + pair_t'({3'd0, units});
  endfunction

  function automatic logic [4:0] month_len(input pair_t mo);
    logic [4:0] n;
    case (mo)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                     n = 5'd30;
      7'd2:                                         n = 5'd28;
      default:                                      n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] days_before(input pair_t mo);
    logic [8:0] n;
    case (mo)
      7'd1:    n = 9'd0;
      7'd2:    n = 9'd31;
      7'd3:    n = 9'd59;
      7'd4:    n = 9'd90;
      7'd5:    n = 9'd120;
      7'd6:    n = 9'd151;
      7'd7:    n = 9'd181;
      7'd8:    n = 9'd212;
      7'd9:    n = 9'd243;
      7'd10:   n = 9'd273;
      7'd11:   n = 9'd304;
      7'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic stamp_valid(input stamp_t s);
    pair_t yy;
    pair_t mo;
    pair_t dd;
    pair_t hh;
    pair_t mi;
    logic [4:0] limit;
    logic ok;
    yy = pair_value(s[0], s[1]);
    mo = pair_value(s[2], s[3]);
    dd = pair_value(s[4], s[5]);
    hh = pair_value(s[6], s[7]);
    mi = pair_value(s[8], s[9]);
    limit = month_len(mo);
    // february 29 in years divisible by four
    if (mo == 7'd2 && yy[1:0] == 2'b00) limit = 5'd29;
    ok = (mo >= 7'd1) && (mo <= 7'd12) && (hh <= 7'd23) && (mi < 7'd60) &&
         (dd >= 7'd1) && (dd <= {2'b00, limit});
    return ok;
  endfunction

  // year*365 + day + days of earlier months + gregorian leap count, where the
  // leap year is one less in january and february (range 1999..2099)
  function automatic day_t day_number(input stamp_t s);
    pair_t yy;
    pair_t mo;
    pair_t dd;
    year_t year;
    year_t lyear;
    logic [9:0] leaps;
    day_t n;
    yy    = pair_value(s[0], s[1]);
    mo    = pair_value(s[2], s[3]);
    dd    = pair_value(s[4], s[5]);
    year  = BaseYear + year_t'(yy);
    lyear = (mo <= 7'd2) ? year - 12'd1 : year;
    // centuries 19 or 20, quad centuries 4 or 5 within this range
    if (lyear >= BaseYear) leaps = lyear[11:2] - 10'd20 + 10'd5;
    else                   leaps = lyear[11:2] - 10'd19 + 10'd4;
    n = day_t'(year * 20'd365) + day_t'(dd) + day_t'(days_before(mo)) + day_t'(leaps);
    return n;
  endfunction

endpackage

/* rtl/core/date_digit_editor_with_day_difference.sv */
// ----------------------------------------------------------------------------
// date_digit_editor_with_day_difference: digit editor for two date stamps
// The result strobe follows the item through edit, two day numbers through
// one shared day-number unit, the difference and the output register.
// A new item is taken only when idle; busy stays high from acceptance until
// the result register loads. The receiver cannot stall the result.
// Reset (synchronous, active low) returns both stamps to 21/01/01 00:00.
// ----------------------------------------------------------------------------
module date_digit_editor_with_day_difference (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_which_stamp,
  input  logic [3:0]  in_position,
  input  logic [3:0]  in_digit_value,
  output logic        out_valid,
  output logic        out_accepted,
  output logic [15:0] out_days_until
);

  dde_pkg::dde_cmd_t cmd;

  // sequencing
  dde_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // storage and arithmetic
  dde_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_which_stamp (in_which_stamp),
    .in_position    (in_position),
    .in_digit_value (in_digit_value),
    .out_valid      (out_valid),
    .out_accepted   (out_accepted),
    .out_days_until (out_days_until)
  );

endmodule

/* rtl/core/dde_ctrl.sv */
// ----------------------------------------------------------------------------
// dde_ctrl: sequencing controller
// Steps one item through edit, two day-number states and result.
// ----------------------------------------------------------------------------
module dde_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output dde_pkg::dde_cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EDIT    = 3'd1;
  localparam logic [2:0] S_DAY_CUR = 3'd2;
  localparam logic [2:0] S_DAY_TGT = 3'd3;
  localparam logic [2:0] S_RESULT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (start) state_nxt = S_EDIT;
      S_EDIT:    state_nxt = S_DAY_CUR;
      S_DAY_CUR: state_nxt = S_DAY_TGT;
      S_DAY_TGT: state_nxt = S_RESULT;
      S_RESULT:  state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // command decode
  assign busy        = (state_r != S_IDLE);
  assign cmd.load_in = (state_r == S_IDLE) && start;
  assign cmd.edit    = (state_r == S_EDIT);
  assign cmd.day_cur = (state_r == S_DAY_CUR);
  assign cmd.day_tgt = (state_r == S_DAY_TGT);
  assign cmd.result  = (state_r == S_RESULT);

endmodule

/* rtl/core/dde_dpath.sv */
// ----------------------------------------------------------------------------
// dde_dpath: stamp storage and date arithmetic
// Holds both stamps, applies and checks one digit edit, forms day numbers and
// the day difference.
// ----------------------------------------------------------------------------
module dde_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  dde_pkg::dde_cmd_t cmd,
  input  logic              in_which_stamp,
  input  logic [3:0]        in_position,
  input  logic [3:0]        in_digit_value,
  output logic              out_valid,
  output logic              out_accepted,
  output logic [15:0]       out_days_until
);

  dde_pkg::stamp_t cur_r;
  dde_pkg::stamp_t tgt_r;
  logic            which_r;
  logic [3:0]      pos_r;
  dde_pkg::digit_t dig_r;
  logic            ok_r;
  dde_pkg::day_t   day_a_r;
  dde_pkg::day_t   day_b_r;
  logic            out_valid_r;
  logic            out_accepted_r;
  logic [15:0]     out_days_r;

  dde_pkg::dde_slot_t slot;
  dde_pkg::stamp_t    cand;
  logic               digit_ok;
  logic               cand_ok;
  logic               commit;
  dde_pkg::day_t      day_sel;

  // candidate stamp with the new digit in place
  always_comb begin
    slot = dde_pkg::slot_of_pos(pos_r);
    for (int k = 0; k < dde_pkg::NumDigits; k++) begin
      cand[k] = which_r ? tgt_r[k] : cur_r[k];
      if (slot.is_digit && slot.slot == 4'(k)) cand[k] = dig_r;
    end
  end

  assign digit_ok = (dig_r <= dde_pkg::MaxDigit);
  assign cand_ok  = dde_pkg::stamp_valid(cand);
  assign commit   = cmd.edit && slot.is_digit && digit_ok && cand_ok;

  // one day-number unit shared between the two stamps
  assign day_sel = dde_pkg::day_number(cmd.day_tgt ? tgt_r : cur_r);

  // stamp storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= dde_pkg::ResetStamp;
      tgt_r <= dde_pkg::ResetStamp;
    end else if (commit) begin
      if (which_r) tgt_r <= cand;
      else         cur_r <= cand;
    end
  end

  // item capture, edit verdict and day numbers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      which_r <= in_which_stamp;
      pos_r   <= in_position;
      dig_r   <= in_digit_value;
    end
    // separators and unused positions are always accepted
    if (cmd.edit)    ok_r    <= !slot.is_digit || (digit_ok && cand_ok);
    if (cmd.day_cur) day_a_r <= day_sel;
    if (cmd.day_tgt) day_b_r <= day_sel;
    if (cmd.result) begin
      out_accepted_r <= ok_r;
      out_days_r     <= 16'(day_b_r - day_a_r);
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.result;
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_days_until = out_days_r;

endmodule

/* rtl/core/dde_checker.sv */
// ----------------------------------------------------------------------------
// dde_checker: port-level checks for the date digit editor
// Watches the command handshake and the result strobe timing.
// ----------------------------------------------------------------------------
module dde_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_accepted,
  input logic [15:0] out_days_until
);

  // an accepted item makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after item accepted");

  // each accepted item is followed by its result strobe
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("result strobe missing after item");

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // result fields are never unknown when shown
  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_accepted, out_days_until}))
    else $error("result fields unknown at strobe");

endmodule

bind date_digit_editor_with_day_difference dde_checker u_dde_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_accepted   (out_accepted),
  .out_days_until (out_days_until)
);
